>>> rtl/imu_serial_frame_decoder_unit_defines.svh
// assertion macros shared by the frame decoder rtl
// no dependencies; included by the modules that carry assertions
`ifndef IMU_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH
`define IMU_SERIAL_FRAME_DECODER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// property holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression never true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> rtl/isfd_pkg.sv
// shared constants, types and the scaling function of the frame decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package isfd_pkg;
    localparam int FRAME_LEN            = 11;
    localparam int MAX_FRAMES_DEFAULT   = 3;
    localparam int POS_W                = 4;
    localparam int STORED_BYTES         = FRAME_LEN - 1;
    localparam int AXIS_W               = 23;
    localparam int EXTRA_W              = 16;

    localparam logic [7:0] HDR_BYTE     = 8'h55;
    localparam logic [7:0] TYPE_ACCEL   = 8'h51;
    localparam logic [7:0] TYPE_RATE    = 8'h52;
    localparam logic [7:0] TYPE_ANGLE   = 8'h53;

    localparam logic [1:0] KIND_ACCEL   = 2'd0;
    localparam logic [1:0] KIND_RATE    = 2'd1;
    localparam logic [1:0] KIND_ANGLE   = 2'd2;

    localparam logic [6:0] MUL_ACCEL    = 7'd125;
    localparam logic [6:0] MUL_RATE     = 7'd125;
    localparam logic [6:0] MUL_ANGLE    = 7'd45;

    // decoded frame at checksum time
    typedef struct packed {
        logic             hit;
        logic [1:0]       kind;
        logic [3:0][15:0] words;
    } t_frame_info;

    // raw signed word times a small unsigned gain, exact in 23 bits
    function automatic logic signed [AXIS_W-1:0] isfd_scale(
        input logic [15:0] w,
        input logic [6:0]  mul
    );
        logic signed [AXIS_W-1:0] a;
        logic signed [AXIS_W-1:0] m;
        a = $signed({{(AXIS_W-16){w[15]}}, w});
        m = $signed({{(AXIS_W-7){1'b0}}, mul});
        return a * m;
    endfunction
endpackage
`default_nettype wire

>>> rtl/isfd_frame_asm.sv
// byte framing, checksum and type decode of the frame decoder
// depends on isfd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "imu_serial_frame_decoder_unit_defines.svh"
module isfd_frame_asm import isfd_pkg::*; #(
    parameter int MAX_FRAMES_PER_BURST = MAX_FRAMES_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_idle,
    input  wire logic [7:0]  i_byte,
    output t_frame_info      o_frame
);
    localparam int FC_W = $clog2(MAX_FRAMES_PER_BURST + 1);
    localparam logic [FC_W-1:0] FC_MAX = FC_W'(MAX_FRAMES_PER_BURST);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(STORED_BYTES);

    logic [7:0]       r_frame_bytes [STORED_BYTES];
    logic [7:0]       r_sum, n_sum;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [FC_W-1:0]  r_frames, n_frames;
    logic             full;
    logic             at_check;

    assign full     = (r_frames >= FC_MAX);
    assign at_check = (r_pos == LAST_POS);

    always_comb begin
        n_sum    = r_sum;
        n_pos    = r_pos;
        n_frames = r_frames;
        if (i_step) begin
            if (i_idle) begin
                n_sum    = '0;
                n_pos    = '0;
                n_frames = '0;
            end else if (!full) begin
                if (at_check) begin
                    n_sum    = '0;
                    n_pos    = '0;
                    n_frames = r_frames + 1'b1;
                end else begin
                    n_sum = r_sum + i_byte;
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_pos    <= '0;
            r_frames <= '0;
        end else begin
            r_sum    <= n_sum;
            r_pos    <= n_pos;
            r_frames <= n_frames;
        end
    end

    // frame byte store, no reset: every byte is written before it is read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORED_BYTES; i++) begin
            if (i_step && !i_idle && !full && r_pos == POS_W'(i)) begin
                r_frame_bytes[i] <= i_byte;
            end
        end
    end

    always_comb begin
        logic good;
        logic known;
        good  = i_step && !i_idle && !full && at_check
                && (r_frame_bytes[0] == HDR_BYTE) && (r_sum == i_byte);
        known = 1'b1;
        o_frame.kind = KIND_ACCEL;
        case (r_frame_bytes[1])
            TYPE_ACCEL: o_frame.kind = KIND_ACCEL;
            TYPE_RATE:  o_frame.kind = KIND_RATE;
            TYPE_ANGLE: o_frame.kind = KIND_ANGLE;
            default:    known = 1'b0;
        endcase
        o_frame.hit = good && known;
        for (int k = 0; k < 4; k++) begin
            o_frame.words[k] = {r_frame_bytes[2*k+3], r_frame_bytes[2*k+2]};
        end
    end

    `ASSERT_NEVER(a_pos_in_frame, i_clk, i_rst_n, r_pos > LAST_POS)
    `ASSERT_NEVER(a_frames_bounded, i_clk, i_rst_n, r_frames > FC_MAX)
    `ASSERT_CLK(a_idle_clears, i_clk, i_rst_n,
        (i_step && i_idle) |=> (r_pos == '0 && r_sum == '0 && r_frames == '0))
endmodule
`default_nettype wire

>>> rtl/imu_serial_frame_decoder_unit.sv
// top level of the serial inertial frame decoder: input register, framing, scaled result register
// depends on isfd_pkg, isfd_frame_asm and the assertion macro header
//
//  channel   dir  tdata bits (low first)              tuser
//  s_axis    in   rx_byte[7:0]                        req_type (1 = line idle)
//  m_axis    out  axis_x, axis_y, axis_z, extra_word  frame_kind[1:0]
//                 [22:0] [45:23] [68:46] [84:69], zero to 88
//
// one transaction per cycle on the input while the result side does not stall; an input is registered
// in the input register, then in the result register; framing, checksum
// compare and the 23-bit gain multiply sit between them
// synchronous active-low reset clears byte position, checksum, frame count and valids
// a stalled result holds the pipeline; the input register still fills while empty
`timescale 1ns / 1ps
`default_nettype none
`include "imu_serial_frame_decoder_unit_defines.svh"
module imu_serial_frame_decoder_unit import isfd_pkg::*; #(
    parameter int MAX_FRAMES_PER_BURST = MAX_FRAMES_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
    input  wire logic [0:0]   s_axis_tuser,   // req_type[0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [87:0]       m_axis_tdata,   // axis_x, axis_y, axis_z, extra_word, zero pad
    output logic [1:0]        m_axis_tuser    // frame_kind[1:0]
);
    // input register
    logic        r_in_valid;
    logic        r_in_idle;
    logic [7:0]  r_in_byte;

    // result register
    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_out_kind;
    logic signed [AXIS_W-1:0]  r_out_x, r_out_y, r_out_z;
    logic [EXTRA_W-1:0]        r_out_extra;

    logic        advance;      // result register free or being drained
    logic        step;         // registered byte processed this cycle
    logic        in_accept;
    t_frame_info frame;
    logic [6:0]  gain;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign step          = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_idle <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    isfd_frame_asm #(
        .MAX_FRAMES_PER_BURST(MAX_FRAMES_PER_BURST)
    ) u_frame_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_idle  (r_in_idle),
        .i_byte  (r_in_byte),
        .o_frame (frame)
    );

    // gain per kind: accel and rate 125, angles 45
    always_comb begin
        case (frame.kind)
            KIND_ACCEL: gain = MUL_ACCEL;
            KIND_RATE:  gain = MUL_RATE;
            KIND_ANGLE: gain = MUL_ANGLE;
            default:    gain = MUL_ACCEL;
        endcase
    end

    assign n_out_valid = advance ? (step && frame.hit) : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && frame.hit) begin
            r_out_kind  <= frame.kind;
            r_out_x     <= isfd_scale(frame.words[0], gain);
            r_out_y     <= isfd_scale(frame.words[1], gain);
            r_out_z     <= isfd_scale(frame.words[2], gain);
            // rate frames carry no extra word
            r_out_extra <= (frame.kind == KIND_RATE) ? '0 : frame.words[3];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {3'b000, r_out_extra, r_out_z, r_out_y, r_out_x};

    `ASSERT_CLK(a_rate_extra_zero, i_clk, i_rst_n,
        (r_out_valid && r_out_kind == KIND_RATE) |-> (r_out_extra == '0))
    `ASSERT_CLK(a_result_from_item, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_in_valid))
    `ASSERT_CLK(a_empty_stage_ready, i_clk, i_rst_n,
        (!r_in_valid) |-> s_axis_tready)
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the serial inertial frame decoder
// needs isfd_pkg and imu_serial_frame_decoder_unit
// bytes and idle events go in, decoded readings are checked
`timescale 1ns / 1ps
module tb_top;
    import isfd_pkg::*;

    localparam int MAX_FRAMES = 3;

    // what the input transaction carries in tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_IDLE = 1'b1;

    // exact gains from raw sensor words to the fixed-point units
    localparam int GAIN_ACCEL = 125;
    localparam int GAIN_RATE  = 125;
    localparam int GAIN_ANGLE = 45;

    // ways a generated frame can be spoiled
    typedef enum int {FAULT_NONE, FAULT_HEADER, FAULT_TYPE, FAULT_SUM, FAULT_NOISE} t_fault;

    typedef struct packed {
        logic [1:0]  kind;
        logic [22:0] x;
        logic [22:0] y;
        logic [22:0] z;
        logic [15:0] extra;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte[7:0]
    logic [0:0]  s_axis_tuser = 1'b0;    // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;           // axis_x, axis_y, axis_z, extra_word, zero pad
    logic [1:0]  m_axis_tuser;           // frame_kind[1:0]

    // predictor state: mirrors the framing of the block
    logic [7:0]  held_bytes [STORED_BYTES];
    logic [7:0]  sum_so_far = 8'h00;
    int          pos_in_frame = 0;
    int          frames_taken = 0;

    t_reading    pending_readings [$];

    int n_sent = 0;
    int n_errors = 0;
    int n_accel = 0;
    int n_rate = 0;
    int n_angle = 0;
    int n_bursts = 0;
    bit quiet = 1'b0;     // final stretch with no idling on either side
    bit calm = 1'b0;      // per-burst stretch with no idling
    int stall_left = 0;

    imu_serial_frame_decoder_unit #(
        .MAX_FRAMES_PER_BURST(MAX_FRAMES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // signed 16-bit little-endian word of the held frame, times a gain, kept to 23 bits
    function automatic logic [22:0] scaled_word(int lo, int gain);
        int v;
        v = $signed({held_bytes[lo + 1], held_bytes[lo]}) * gain;
        return v[22:0];
    endfunction

    // advance the predictor by one accepted transaction
    function automatic void decode_byte(logic req, logic [7:0] b);
        t_reading r;
        int       gain;
        bit       good;
        if (req == REQ_IDLE) begin
            pos_in_frame = 0;
            sum_so_far   = 8'h00;
            frames_taken = 0;
            return;
        end
        if (frames_taken >= MAX_FRAMES)
            return;
        if (pos_in_frame < STORED_BYTES) begin
            held_bytes[pos_in_frame] = b;
            sum_so_far = sum_so_far + b;
            pos_in_frame++;
            return;
        end
        // checksum byte closes the frame
        good = (held_bytes[0] == HDR_BYTE) && (sum_so_far == b);
        pos_in_frame = 0;
        sum_so_far   = 8'h00;
        frames_taken++;
        if (!good)
            return;
        case (held_bytes[1])
            TYPE_ACCEL: begin
                r.kind  = KIND_ACCEL;
                gain    = GAIN_ACCEL;
                r.extra = {held_bytes[9], held_bytes[8]};
            end
            TYPE_RATE: begin
                r.kind  = KIND_RATE;
                gain    = GAIN_RATE;
                r.extra = 16'h0000;
            end
            TYPE_ANGLE: begin
                r.kind  = KIND_ANGLE;
                gain    = GAIN_ANGLE;
                r.extra = {held_bytes[9], held_bytes[8]};
            end
            default: return;
        endcase
        r.x = scaled_word(2, gain);
        r.y = scaled_word(4, gain);
        r.z = scaled_word(6, gain);
        pending_readings.push_back(r);
    endfunction

    // offer one transaction, hold it until taken, then update the prediction
    task automatic send_item(input logic req, input logic [7:0] b);
        int gap;
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(req, b);
        n_sent++;
    endtask

    // one 11-byte frame with a correct checksum unless a fault says otherwise
    task automatic send_frame(input logic [7:0] kind, input logic [3:0][15:0] words,
                              input t_fault fault);
        logic [7:0] fb [FRAME_LEN];
        logic [7:0] sum;
        int         k;
        fb[0] = HDR_BYTE;
        fb[1] = kind;
        for (k = 0; k < 4; k++) begin
            fb[2 + 2 * k] = words[k][7:0];
            fb[3 + 2 * k] = words[k][15:8];
        end
        case (fault)
            FAULT_HEADER: fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            FAULT_TYPE:   fb[1] = 8'($urandom_range(0, 255));
            FAULT_NOISE:  for (k = 0; k < STORED_BYTES; k++) fb[k] = 8'($urandom_range(0, 255));
            default: ;
        endcase
        sum = 8'h00;
        for (k = 0; k < STORED_BYTES; k++) sum = sum + fb[k];
        fb[FRAME_LEN - 1] = sum;
        if (fault == FAULT_SUM)
            fb[FRAME_LEN - 1] = sum ^ 8'($urandom_range(1, 255));
        else if (fault == FAULT_NOISE && $urandom_range(0, 1) == 0)
            fb[FRAME_LEN - 1] = 8'($urandom_range(0, 255));
        for (k = 0; k < FRAME_LEN; k++) send_item(REQ_BYTE, fb[k]);
    endtask

    // random word, leaning toward the range ends now and then
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 2))
            0:       return TYPE_ACCEL;
            1:       return TYPE_RATE;
            default: return TYPE_ANGLE;
        endcase
    endfunction

    // idle event, a few frames, sometimes an over-full burst or a dangling partial frame
    task automatic send_burst(input bit damaged);
        logic [3:0][15:0] w;
        t_fault           fault;
        int               nf;
        int               k;
        int               j;
        int               tail;
        calm = ($urandom_range(0, 3) == 0);
        n_bursts++;
        send_item(REQ_IDLE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            send_item(REQ_IDLE, 8'($urandom_range(0, 255)));
        nf = $urandom_range(1, MAX_FRAMES);
        if ($urandom_range(0, 5) == 0)
            nf = MAX_FRAMES + 1 + $urandom_range(0, 1);
        for (k = 0; k < nf; k++) begin
            for (j = 0; j < 4; j++) w[j] = pick_word();
            fault = FAULT_NONE;
            if (damaged && $urandom_range(0, 2) == 0)
                fault = t_fault'($urandom_range(1, 4));
            send_frame(pick_type(), w, fault);
        end
        // partial frame that the next idle event throws away
        if ((damaged && $urandom_range(0, 1) == 0) || $urandom_range(0, 7) == 0) begin
            tail = $urandom_range(1, FRAME_LEN - 1);
            send_item(REQ_BYTE, HDR_BYTE);
            for (k = 1; k < tail; k++) send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    // bytes before any idle event, range-end words, back-to-back frames in one burst
    task automatic test_first_burst();
        send_frame(TYPE_ACCEL, {16'h8000, 16'h7fff, 16'h7fff, 16'h7fff}, FAULT_NONE);
        send_frame(TYPE_ANGLE, {16'h7fff, 16'h8000, 16'h8000, 16'h8000}, FAULT_NONE);
        send_item(REQ_IDLE, 8'hff);
    endtask

    task automatic test_clean_bursts(input int upto);
        while (n_sent < upto) send_burst(1'b0);
    endtask

    task automatic test_damaged_bursts(input int upto);
        while (n_sent < upto) send_burst(1'b1);
    endtask

    // last stretch without any idling on either side
    task automatic test_quiet_tail(input int upto);
        quiet = 1'b1;
        while (n_sent < upto) send_burst(1'b0);
    endtask

    // receiver side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t ns %s mismatch: expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // every result transaction against the oldest predicted reading
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t ns unexpected result: expected none actual kind %0d data %0h",
                             $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_readings.pop_front();
                check_field("frame_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("axis_x", 32'(want.x), 32'(m_axis_tdata[22:0]));
                check_field("axis_y", 32'(want.y), 32'(m_axis_tdata[45:23]));
                check_field("axis_z", 32'(want.z), 32'(m_axis_tdata[68:46]));
                check_field("extra_word", 32'(want.extra), 32'(m_axis_tdata[84:69]));
                check_field("pad bits", 32'd0, 32'(m_axis_tdata[87:85]));
                case (want.kind)
                    KIND_ACCEL: n_accel++;
                    KIND_RATE:  n_rate++;
                    default:    n_angle++;
                endcase
            end
        end
    end

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_burst();
        test_clean_bursts(1100);
        test_damaged_bursts(1750);
        test_quiet_tail(1900);
        s_axis_tvalid <= 1'b0;

        // drain outstanding readings, then wait for anything stray
        for (k = 0; k < 500 && pending_readings.size() != 0; k++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            $display("%0t ns %0d readings expected but never delivered", $time,
                     pending_readings.size());
            n_errors += pending_readings.size();
        end

        $display("sent %0d transactions in %0d bursts, with clean, damaged and over-full frames",
                 n_sent, n_bursts);
        $display("readings checked: %0d acceleration, %0d rate, %0d angle; %0d mismatches",
                 n_accel, n_rate, n_angle, n_errors);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
